@@ sv/btl_pkg.sv @@
package btl_pkg;

  localparam int TOTAL_W     = 9;
  localparam int POS_W       = 16;
  localparam int DIM_W       = 15;
  localparam int COUNT_W     = 8;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_WINDOWS_DEF = 256;

  localparam logic [FRAC_W-1:0]  DEFAULT_FRACTION = 16'd36045;
  localparam logic [COUNT_W-1:0] DEFAULT_MASTERS  = 8'd1;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [TOTAL_W-1:0]      total_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_X      = 3'd0,
    REG_AREA_Y      = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_MASTER_CNT  = 3'd4,
    REG_MASTER_FRAC = 3'd5
  } cfg_reg_t;

endpackage

@@ sv/btl_if.sv @@
interface btl_in_if;
  import btl_pkg::*;
  logic   valid;
  logic   ready;
  total_t window_total;
  logic   first_window;
  modport source (output valid, window_total, first_window, input ready);
  modport sink   (input valid, window_total, first_window, output ready);
endinterface

interface btl_out_if;
  import btl_pkg::*;
  logic valid;
  logic ready;
  pos_t win_x;
  pos_t win_y;
  dim_t win_w;
  dim_t win_h;
  logic last_window;
  modport source (output valid, win_x, win_y, win_w, win_h, last_window, input ready);
  modport sink   (input valid, win_x, win_y, win_w, win_h, last_window, output ready);
endinterface

interface btl_cfg_if;
  import btl_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bottom_stack_tile_layout_core.sv @@
// Channel  Dir  Payload                                       Handshake
// in_if    in   window_total[8:0], first_window               valid/ready
// out_if   out  win_x[15:0], win_y[15:0], win_w, win_h,       valid/ready
//               last_window
// cfg_if   in   index[2:0], data[15:0]                        valid/ready
//
// The band-height multiply runs at the accepting edge. The result then passes
// band select (S_BAND), setup (S_SETUP), 15 steps of the shared radix-2 divider
// (S_DIV) and the output load (S_DONE). Ready rises with that load, so a new
// item is not taken until the last one has been loaded; ready does not wait for the
// result to leave the output register.
// A finished item waits in the last state while out_if is stalled.
// rst_n is synchronous; it clears the sequencer and loads register defaults.
module bottom_stack_tile_layout_core #(
  parameter int MAX_WINDOWS = btl_pkg::MAX_WINDOWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  btl_in_if.sink     in_if,
  btl_out_if.source  out_if,
  btl_cfg_if.sink    cfg_if
);
  import btl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOWS + 1);
  localparam int CMP_W  = (IDX_W > TOTAL_W) ? IDX_W : TOTAL_W;
  localparam int MC_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int REM_W  = ((IDX_W > DIM_W) ? IDX_W : DIM_W) + 1;
  localparam int PROD_W = DIM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIM_W);

  typedef enum logic [2:0] {S_IDLE, S_BAND, S_SETUP, S_DIV, S_DONE} state_t;

  typedef logic [IDX_W-1:0] idx_t;

  state_t state_r;

  pos_t                area_x_r, area_y_r;
  dim_t                area_w_r, area_h_r;
  logic [COUNT_W-1:0]  mcount_r;
  logic [FRAC_W-1:0]   mfrac_r;

  idx_t                total_r, idx_r, eff_r, div_r;
  dim_t                mcur_r, scur_r, band_r, cur_r, quo_r;
  logic [PROD_W-1:0]   prod_r;
  logic                start_r, is_m_r;
  logic [REM_W-1:0]    rem_r;
  logic [STEP_W-1:0]   step_r;

  logic                out_valid_r, last_r;
  pos_t                win_x_r, win_y_r;
  dim_t                win_w_r, win_h_r;

  logic [CMP_W-1:0]    raw_ext, max_ext;
  idx_t                total_c, eff_c;
  logic [MC_W-1:0]     mc_ext, tot_ext;
  logic                start_c;
  logic [FRAC_W-1:0]   frac_c;

  logic                is_m_c;
  dim_t                cur_c, span_c;
  idx_t                div_c;

  logic [REM_W-1:0]    trial, div_ext;
  logic                qbit;

  logic                in_fire, out_free;
  idx_t                idx_inc;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign idx_inc  = idx_r + idx_t'(1);

  always_comb begin
    raw_ext = CMP_W'(in_if.window_total);
    max_ext = CMP_W'(MAX_WINDOWS);
    if (raw_ext == '0) begin
      total_c = idx_t'(1);
    end else if (raw_ext > max_ext) begin
      total_c = idx_t'(max_ext);
    end else begin
      total_c = idx_t'(raw_ext);
    end
    mc_ext  = MC_W'(mcount_r);
    tot_ext = MC_W'(total_c);
    eff_c   = (mc_ext < tot_ext) ? idx_t'(mc_ext) : total_c;
    start_c = in_if.first_window || (idx_r == '0) || (idx_r >= total_c);
    frac_c  = (mfrac_r == '0) ? DEFAULT_FRACTION : mfrac_r;
  end

  always_comb begin
    is_m_c = idx_r < eff_r;
    cur_c  = is_m_c ? mcur_r : scur_r;
    span_c = (area_w_r > cur_c) ? (area_w_r - cur_c) : '0;
    div_c  = is_m_c ? (eff_r - idx_r) : (total_r - idx_r);
  end

  always_comb begin
    trial   = {rem_r[REM_W-2:0], quo_r[DIM_W-1]};
    div_ext = REM_W'(div_r);
    qbit    = trial >= div_ext;
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.win_x        = win_x_r;
  assign out_if.win_y        = win_y_r;
  assign out_if.win_w        = win_w_r;
  assign out_if.win_h        = win_h_r;
  assign out_if.last_window  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      area_x_r    <= '0;
      area_y_r    <= '0;
      area_w_r    <= '0;
      area_h_r    <= '0;
      mcount_r    <= DEFAULT_MASTERS;
      mfrac_r     <= DEFAULT_FRACTION;
      idx_r       <= '0;
      mcur_r      <= '0;
      scur_r      <= '0;
      band_r      <= '0;
      eff_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_AREA_X:      area_x_r <= pos_t'(cfg_if.data);
          REG_AREA_Y:      area_y_r <= pos_t'(cfg_if.data);
          REG_AREA_WIDTH:  area_w_r <= cfg_if.data[DIM_W-1:0];
          REG_AREA_HEIGHT: area_h_r <= cfg_if.data[DIM_W-1:0];
          REG_MASTER_CNT:  mcount_r <= cfg_if.data[COUNT_W-1:0];
          REG_MASTER_FRAC: mfrac_r  <= cfg_if.data[FRAC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_if.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            total_r <= total_c;
            start_r <= start_c;
            prod_r  <= PROD_W'(area_h_r) * PROD_W'(frac_c);
            if (start_c) begin
              idx_r  <= '0;
              mcur_r <= '0;
              scur_r <= '0;
              eff_r  <= eff_c;
            end
            state_r <= S_BAND;
          end
        end
        S_BAND: begin
          if (start_r) begin
            if (eff_r == '0 || eff_r == total_r) begin
              band_r <= area_h_r;
            end else begin
              band_r <= prod_r[PROD_W-1:FRAC_W];
            end
          end
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          is_m_r  <= is_m_c;
          cur_r   <= cur_c;
          div_r   <= div_c;
          quo_r   <= span_c;
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= qbit ? (trial - div_ext) : trial;
          quo_r  <= {quo_r[DIM_W-2:0], qbit};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIM_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            win_x_r     <= area_x_r + pos_t'({1'b0, cur_r});
            win_w_r     <= quo_r;
            last_r      <= (idx_inc == total_r);
            if (is_m_r) begin
              mcur_r  <= cur_r + quo_r;
              win_y_r <= area_y_r;
              win_h_r <= band_r;
            end else begin
              scur_r  <= cur_r + quo_r;
              win_y_r <= area_y_r + pos_t'({1'b0, band_r});
              win_h_r <= (area_h_r > band_r) ? (area_h_r - band_r) : '0;
            end
            idx_r   <= idx_inc;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_bottom_stack_tile_layout_core.sv @@
module tb_bottom_stack_tile_layout_core;
  timeunit 1ns;
  timeprecision 1ps;

  import btl_pkg::*;

  localparam int MAX_WIN     = MAX_WINDOWS_DEF;
  localparam int N_ITEMS     = 1250;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    pos_t x;
    pos_t y;
    dim_t w;
    dim_t h;
    logic last;
  } rect_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t kind;
    cfg_reg_t  sel;
    cfg_data_t data;
    total_t    total;
    logic      first_w;
    bit        fixed;
    rect_t     want;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  btl_in_if  in_if ();
  btl_out_if out_if ();
  btl_cfg_if cfg_if ();

  bottom_stack_tile_layout_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #2 clk = ~clk;

  // register shadow
  pos_t              area_x      = '0;
  pos_t              area_y      = '0;
  dim_t              area_w      = '0;
  dim_t              area_h      = '0;
  logic [COUNT_W-1:0] master_cnt = DEFAULT_MASTERS;
  logic [FRAC_W-1:0]  master_frac = DEFAULT_FRACTION;

  // layout state
  int unsigned win_idx     = 0;
  int unsigned master_cur  = 0;
  int unsigned stack_cur   = 0;
  int unsigned band_h      = 0;
  int unsigned eff_masters = 0;

  rect_t pending_rects[$];
  int    n_sent    = 0;
  int    n_results = 0;
  int    n_errors  = 0;
  int    n_cycles  = 0;

  function automatic rect_t place_window(total_t raw_total, logic first_w);
    int unsigned n, frac, span, w, h, cur;
    int          x, y;
    rect_t       r;
    n = 32'(raw_total);
    if (n == 0) n = 1;
    if (n > MAX_WIN) n = MAX_WIN;
    if (first_w || win_idx == 0 || win_idx >= n) begin
      frac        = 32'((master_frac != 0) ? master_frac : DEFAULT_FRACTION);
      win_idx     = 0;
      master_cur  = 0;
      stack_cur   = 0;
      eff_masters = (32'(master_cnt) < n) ? 32'(master_cnt) : n;
      if (eff_masters == 0 || eff_masters == n) begin
        band_h = 32'(area_h);
      end else begin
        band_h = (32'(area_h) * frac) >> 16;
      end
    end
    if (win_idx < eff_masters) begin
      cur        = master_cur;
      span       = (32'(area_w) > cur) ? 32'(area_w) - cur : 0;
      w          = span / (eff_masters - win_idx);
      master_cur = cur + w;
      y          = int'(area_y);
      h          = band_h;
    end else begin
      cur       = stack_cur;
      span      = (32'(area_w) > cur) ? 32'(area_w) - cur : 0;
      w         = span / (n - win_idx);
      stack_cur = cur + w;
      y         = int'(area_y) + int'(band_h);
      h         = (32'(area_h) > band_h) ? 32'(area_h) - band_h : 0;
    end
    x      = int'(area_x) + int'(cur);
    r.x    = x[15:0];
    r.y    = y[15:0];
    r.w    = w[DIM_W-1:0];
    r.h    = h[DIM_W-1:0];
    r.last = (win_idx + 1 == n);
    win_idx++;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t sel, cfg_data_t data);
    plan_row_t p;
    p = '{kind: ROW_CFG, sel: sel, data: data, total: '0, first_w: 1'b0, fixed: 1'b0,
          want: '0};
    return p;
  endfunction

  function automatic plan_row_t item_row(total_t t, logic f);
    plan_row_t p;
    p = '{kind: ROW_ITEM, sel: REG_AREA_X, data: '0, total: t, first_w: f, fixed: 1'b0,
          want: '0};
    return p;
  endfunction

  function automatic plan_row_t fixed_row(total_t t, logic f, rect_t r);
    plan_row_t p;
    p       = item_row(t, f);
    p.fixed = 1'b1;
    p.want  = r;
    return p;
  endfunction

  function automatic int pick_total();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return int'($urandom_range(1, 8));
    if (r < 90) return int'($urandom_range(9, 40));
    if (r < 97) return int'($urandom_range(41, 255));
    return MAX_WIN;
  endfunction

  function automatic cfg_data_t reg_value(cfg_reg_t sel);
    int unsigned r;
    r = $urandom_range(7);
    case (sel)
      REG_AREA_X, REG_AREA_Y: begin
        case (r)
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return cfg_data_t'($urandom_range(16'hFFFF));
        endcase
      end
      REG_AREA_WIDTH, REG_AREA_HEIGHT: begin
        case (r)
          0: return 16'h0000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          3, 4: return cfg_data_t'($urandom_range(0, 64));
          default: return cfg_data_t'($urandom_range(16'hFFFF));
        endcase
      end
      REG_MASTER_CNT: begin
        case (r)
          0: return 16'h0000;
          1: return 16'h00FF;
          2: return cfg_data_t'($urandom_range(16'hFFFF));
          default: return cfg_data_t'($urandom_range(1, 6));
        endcase
      end
      default: begin
        case (r)
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h0001;
          default: return cfg_data_t'($urandom_range(16'hFFFF));
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t sel, cfg_data_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (sel)
      REG_AREA_X:      area_x      = data;
      REG_AREA_Y:      area_y      = data;
      REG_AREA_WIDTH:  area_w      = data[DIM_W-1:0];
      REG_AREA_HEIGHT: area_h      = data[DIM_W-1:0];
      REG_MASTER_CNT:  master_cnt  = data[COUNT_W-1:0];
      REG_MASTER_FRAC: master_frac = data;
      default: ;
    endcase
  endtask

  task automatic offer_window(total_t t, logic f, bit fixed, rect_t want);
    rect_t r;
    cfg_if.valid <= 1'b0;
    if (!(n_sent >= 400 && n_sent < 650) && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.window_total <= t;
    in_if.first_window <= f;
    do @(posedge clk); while (!in_if.ready);
    r = place_window(t, f);
    pending_rects.push_back(fixed ? want : r);
    n_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rects.size() != 0);
  endtask

  initial begin : stimulus
    plan_row_t   plan[$];
    int unsigned tot, phase_end, sel, k, carry_tot, carry_left;
    in_if.valid        <= 1'b0;
    in_if.window_total <= '0;
    in_if.first_window <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_AREA_X;
    cfg_if.data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset the area is empty; a zero total counts as one
    plan.push_back(fixed_row(9'd1, 1'b1, '{16'sh0000, 16'sh0000, 15'h0, 15'h0, 1'b1}));
    plan.push_back(fixed_row(9'd0, 1'b0, '{16'sh0000, 16'sh0000, 15'h0, 15'h0, 1'b1}));
    plan.push_back(cfg_row(REG_AREA_X, 16'h8000));
    plan.push_back(cfg_row(REG_AREA_Y, 16'h7FFF));
    plan.push_back(cfg_row(REG_AREA_WIDTH, 16'h7FFF));
    plan.push_back(cfg_row(REG_AREA_HEIGHT, 16'h7FFF));
    plan.push_back(cfg_row(REG_MASTER_CNT, 16'h00FF));
    plan.push_back(cfg_row(REG_MASTER_FRAC, 16'hFFFF));
    // lone window takes the whole area
    plan.push_back(fixed_row(9'd1, 1'b1, '{16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 1'b1}));
    // oversized total clamps
    plan.push_back(item_row(9'h1FF, 1'b1));
    plan.push_back(item_row(9'h100, 1'b0));
    plan.push_back(item_row(9'h100, 1'b0));
    // zero fraction means default; with no masters the band takes the full height and stack windows get zero height
    plan.push_back(cfg_row(REG_MASTER_FRAC, 16'h0000));
    plan.push_back(cfg_row(REG_MASTER_CNT, 16'h0000));
    plan.push_back(item_row(9'd3, 1'b1));
    plan.push_back(item_row(9'd3, 1'b0));
    // x wraps past the top of the range
    plan.push_back(cfg_row(REG_AREA_X, 16'h7FFF));
    plan.push_back(cfg_row(REG_AREA_WIDTH, 16'd100));
    plan.push_back(cfg_row(REG_AREA_HEIGHT, 16'd50));
    plan.push_back(cfg_row(REG_MASTER_CNT, 16'd2));
    plan.push_back(cfg_row(REG_MASTER_FRAC, 16'h8000));
    plan.push_back(item_row(9'd3, 1'b1));
    // width shrinks below the cursor mid-arrangement
    plan.push_back(cfg_row(REG_AREA_WIDTH, 16'd10));
    plan.push_back(item_row(9'd3, 1'b0));
    plan.push_back(item_row(9'd3, 1'b0));
    plan.push_back(item_row(9'd3, 1'b0));
    // more masters than windows
    plan.push_back(cfg_row(REG_MASTER_CNT, 16'd8));
    plan.push_back(item_row(9'd4, 1'b1));
    plan.push_back(item_row(9'd4, 1'b0));
    // tiny fraction is unused when every window is a master; the band takes the full height
    plan.push_back(cfg_row(REG_MASTER_FRAC, 16'h0001));
    plan.push_back(cfg_row(REG_AREA_WIDTH, 16'h0000));
    plan.push_back(item_row(9'd2, 1'b1));
    plan.push_back(item_row(9'd2, 1'b0));

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        wait_for_results();
        write_reg(plan[r].sel, plan[r].data);
      end else begin
        offer_window(plan[r].total, plan[r].first_w, plan[r].fixed, plan[r].want);
      end
    end

    carry_tot  = 0;
    carry_left = 0;
    while (n_sent < N_ITEMS) begin
      wait_for_results();
      for (int i = 0; i <= int'(REG_MASTER_FRAC); i++) begin
        if ($urandom_range(2) != 0) write_reg(cfg_reg_t'(i), reg_value(cfg_reg_t'(i)));
      end
      phase_end = n_sent + $urandom_range(40, 160);
      // finish an arrangement left open across the register change
      while (carry_left != 0) begin
        offer_window(total_t'(carry_tot), 1'b0, 1'b0, '0);
        carry_left--;
      end
      while (n_sent < phase_end) begin
        tot = pick_total();
        sel = $urandom_range(99);
        if (sel < 75) begin
          for (int i = 0; i < tot; i++) begin
            offer_window(total_t'(tot), (i == 0) ? ($urandom_range(9) != 0) : 1'b0, 1'b0,
                         '0);
          end
        end else if (sel < 90) begin
          k = $urandom_range(1, tot);
          for (int i = 0; i < k; i++) offer_window(total_t'(tot), i == 0, 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            offer_window(total_t'($urandom_range(0, 511)), 1'($urandom_range(1)), 1'b0, '0);
          end
        end
      end
      if ($urandom_range(3) == 0) begin
        tot = pick_total();
        if (tot > 1) begin
          k = $urandom_range(1, tot - 1);
          for (int i = 0; i < k; i++) offer_window(total_t'(tot), i == 0, 1'b0, '0);
          carry_tot  = tot;
          carry_left = tot - k;
        end
      end
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (n_errors == 0 && pending_rects.size() == 0) begin
      $display("PASS bottom_stack_tile_layout_core");
    end else begin
      $display("FAIL bottom_stack_tile_layout_core");
    end
    $finish;
  end

  initial begin : result_sink
    rect_t got, want;
    int    hold_left;
    bit    hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{out_if.win_x, out_if.win_y, out_if.win_w, out_if.win_h, out_if.last_window};
        if (pending_rects.size() == 0) begin
          n_errors++;
          if (n_errors <= SHOW_ERRORS)
            $display("unexpected window x=%0d y=%0d w=%0d h=%0d last=%0b",
                     got.x, got.y, got.w, got.h, got.last);
        end else begin
          want = pending_rects.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= SHOW_ERRORS) begin
              $write("window %0d: expected x=%0d y=%0d w=%0d h=%0d last=%0b, ",
                     n_results, want.x, want.y, want.w, want.h, want.last);
              $display("got x=%0d y=%0d w=%0d h=%0d last=%0b",
                       got.x, got.y, got.w, got.h, got.last);
            end
          end
        end
        n_results++;
      end
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && n_results >= 200 && in_if.valid) begin
        // long back-pressure while items keep coming
        hold_done = 1'b1;
        hold_left = 400;
        out_if.ready <= 1'b0;
      end else if (n_results >= 400 && n_results < 650) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL bottom_stack_tile_layout_core");
      $finish;
    end
  end

endmodule

@@ sim.f @@
sv/btl_pkg.sv
sv/btl_if.sv
sv/bottom_stack_tile_layout_core.sv
tb/sv/tb_bottom_stack_tile_layout_core.sv
